FILE: hw/rtl/scp_pkg.sv
// shared types, constants and helpers for the sprite camera projection unit
package scp_pkg;

  localparam int POS_FRAC_BITS_DEF     = 16;
  localparam int SCREEN_COORD_BITS_DEF = 16;
  localparam int VEC_FRAC              = 14;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_POS_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_POS_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H     = 4'd7;

  // first divider: camera transform numerators and determinant magnitude
  localparam int NUM1_W = 64;
  localparam int DEN_W  = 32;
  // second divider numerator width floor (centre column product)
  localparam int NUM2_MIN_W = 42;

  typedef struct packed {
    logic signed [31:0] player_pos_x;
    logic signed [31:0] player_pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic [10:0]        screen_width;
    logic [10:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic               det_zero;
    logic signed [31:0] vm;
  } div1_pay_t;

  typedef struct packed {
    logic               sing;
    logic               neg_cx;
    logic               neg_sh;
    logic signed [31:0] ty;
  } div2_pay_t;

  // signed quotient from magnitude, saturated to 32 bits
  function automatic logic signed [31:0] clamp32(input logic neg, input logic [63:0] mag);
    logic signed [31:0] t;
    t = mag[31:0];
    if (!neg) begin
      return (mag > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : t;
    end else begin
      return (mag > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -t;
    end
  endfunction

endpackage

FILE: hw/rtl/scp_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, shared divisor
module scp_div_pipe #(
  parameter int LANES = 2,
  parameter int NW    = 64,
  parameter int DW    = 32,
  parameter int PW    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [PW-1:0]              in_pay,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   out_quo,
  output logic [PW-1:0]              out_pay
);

  logic                     v_r [NW+1];
  logic [LANES-1:0][NW-1:0] n_r [NW+1];
  logic [LANES-1:0][DW-1:0] rem_r [NW+1];
  logic [DW-1:0]            d_r [NW+1];
  logic [PW-1:0]            p_r [NW+1];

  assign v_r[0]   = in_valid;
  assign n_r[0]   = in_num;
  assign rem_r[0] = '0;
  assign d_r[0]   = in_den;
  assign p_r[0]   = in_pay;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [LANES-1:0][NW-1:0] n_nxt;
    logic [LANES-1:0][DW-1:0] rem_nxt;

    always_comb begin
      logic [DW:0] trial;
      trial   = '0;
      n_nxt   = '0;
      rem_nxt = '0;
      for (int l = 0; l < LANES; l++) begin
        // numerator shifts out on top while quotient bits shift in below
        trial = {rem_r[s][l], n_r[s][l][NW-1]};
        if (trial >= {1'b0, d_r[s]}) begin
          rem_nxt[l] = DW'(trial - {1'b0, d_r[s]});
          n_nxt[l]   = {n_r[s][l][NW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[DW-1:0];
          n_nxt[l]   = {n_r[s][l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
      n_r[s+1]   <= n_nxt;
      rem_r[s+1] <= rem_nxt;
      d_r[s+1]   <= d_r[s];
      p_r[s+1]   <= p_r[s];
    end
  end

  assign out_valid = v_r[NW];
  assign out_quo   = n_r[NW];
  assign out_pay   = p_r[NW];

endmodule

FILE: hw/rtl/scp_front.sv
// front stages: sprite offset, camera products, determinant, divider operands
module scp_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  scp_pkg::cfg_t                         cfg,
  input  logic                                  in_valid,
  input  logic signed [31:0]                    sprite_x,
  input  logic signed [31:0]                    sprite_y,
  input  logic signed [31:0]                    vertical_move,
  output logic                                  out_valid,
  output logic [1:0][scp_pkg::NUM1_W-1:0]       out_num,
  output logic [scp_pkg::DEN_W-1:0]             out_den,
  output scp_pkg::div1_pay_t                    out_pay
);

  // stage 1
  logic               v1_r;
  logic signed [32:0] ox_r, oy_r;
  logic signed [31:0] vm1_r, pd1_r, pd2_r;
  // stage 2
  logic               v2_r;
  logic signed [48:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [32:0] det2_r;
  logic signed [31:0] vm2_r;
  // stage 3
  logic               v3_r;
  logic signed [49:0] dfx_r, dfy_r;
  logic signed [32:0] det3_r;
  logic signed [31:0] vm3_r;
  // stage 4
  logic                            v4_r;
  logic [1:0][scp_pkg::NUM1_W-1:0] num4_r;
  logic [scp_pkg::DEN_W-1:0]       den4_r;
  scp_pkg::div1_pay_t              pay4_r;

  logic signed [49:0] absx, absy;
  logic signed [32:0] absd;

  always_comb begin
    absx = dfx_r[49] ? -dfx_r : dfx_r;
    absy = dfy_r[49] ? -dfy_r : dfy_r;
    absd = det3_r[32] ? -det3_r : det3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    ox_r   <= {sprite_x[31], sprite_x} - {cfg.player_pos_x[31], cfg.player_pos_x};
    oy_r   <= {sprite_y[31], sprite_y} - {cfg.player_pos_y[31], cfg.player_pos_y};
    vm1_r  <= vertical_move;
    pd1_r  <= cfg.plane_x * cfg.dir_y;
    pd2_r  <= cfg.dir_x * cfg.plane_y;

    m1_r   <= cfg.dir_y * ox_r;
    m2_r   <= cfg.dir_x * oy_r;
    m3_r   <= cfg.plane_x * oy_r;
    m4_r   <= cfg.plane_y * ox_r;
    det2_r <= {pd1_r[31], pd1_r} - {pd2_r[31], pd2_r};
    vm2_r  <= vm1_r;

    dfx_r  <= {m1_r[48], m1_r} - {m2_r[48], m2_r};
    dfy_r  <= {m3_r[48], m3_r} - {m4_r[48], m4_r};
    det3_r <= det2_r;
    vm3_r  <= vm2_r;

    // scale by one in Q2.14 before the divide
    num4_r[0]       <= {absx, {scp_pkg::VEC_FRAC{1'b0}}};
    num4_r[1]       <= {absy, {scp_pkg::VEC_FRAC{1'b0}}};
    den4_r          <= absd[31:0];
    pay4_r.neg_x    <= dfx_r[49] ^ det3_r[32];
    pay4_r.neg_y    <= dfy_r[49] ^ det3_r[32];
    pay4_r.det_zero <= (det3_r == '0);
    pay4_r.vm       <= vm3_r;
  end

  assign out_valid = v4_r;
  assign out_num   = num4_r;
  assign out_den   = den4_r;
  assign out_pay   = pay4_r;

endmodule

FILE: hw/rtl/scp_mid.sv
// middle stages: clamp camera coordinates, form the screen-space divider operands
module scp_mid #(
  parameter int POS_FRAC_BITS = scp_pkg::POS_FRAC_BITS_DEF,
  parameter int NUM2_W        = scp_pkg::NUM2_MIN_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scp_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  input  logic [1:0][scp_pkg::NUM1_W-1:0]     in_quo,
  input  scp_pkg::div1_pay_t                  in_pay,
  output logic                                out_valid,
  output logic [2:0][NUM2_W-1:0]              out_num,
  output logic [scp_pkg::DEN_W-1:0]           out_den,
  output scp_pkg::div2_pay_t                  out_pay
);

  // stage 1
  logic               v1_r, dz1_r;
  logic signed [31:0] tx_r, ty1_r, vm1_r;
  // stage 2
  logic               v2_r, sing2_r, nsh2_r;
  logic signed [32:0] sum_r;
  logic [31:0]        vmag2_r, tmag2_r;
  logic signed [31:0] ty2_r;
  // stage 3
  logic               v3_r, sing3_r, nsh3_r;
  logic signed [42:0] prod_r;
  logic [31:0]        vmag3_r, tmag3_r;
  logic signed [31:0] ty3_r;
  // stage 4
  logic                     v4_r;
  logic [2:0][NUM2_W-1:0]   num4_r;
  logic [scp_pkg::DEN_W-1:0] den4_r;
  scp_pkg::div2_pay_t       pay4_r;

  logic signed [32:0] vm_ext, ty_ext;
  logic signed [42:0] prod_abs;

  always_comb begin
    vm_ext   = {vm1_r[31], vm1_r};
    ty_ext   = {ty1_r[31], ty1_r};
    prod_abs = prod_r[42] ? -prod_r : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    tx_r  <= scp_pkg::clamp32(in_pay.neg_x, in_quo[0]);
    ty1_r <= scp_pkg::clamp32(in_pay.neg_y, in_quo[1]);
    dz1_r <= in_pay.det_zero;
    vm1_r <= in_pay.vm;

    sing2_r <= dz1_r | (ty1_r == '0);
    sum_r   <= {tx_r[31], tx_r} + ty_ext;
    vmag2_r <= vm_ext[32] ? 32'(-vm_ext) : vm_ext[31:0];
    tmag2_r <= ty_ext[32] ? 32'(-ty_ext) : ty_ext[31:0];
    // shift is -vm / ty, so the sign of vm counts inverted
    nsh2_r  <= ~vm1_r[31] ^ ty1_r[31];
    ty2_r   <= ty1_r;

    prod_r  <= $signed({1'b0, cfg.screen_width[10:1]}) * sum_r;
    sing3_r <= sing2_r;
    nsh3_r  <= nsh2_r;
    vmag3_r <= vmag2_r;
    tmag3_r <= tmag2_r;
    ty3_r   <= ty2_r;

    num4_r[0]     <= NUM2_W'(prod_abs[41:0]);
    num4_r[1]     <= NUM2_W'(vmag3_r);
    num4_r[2]     <= NUM2_W'(cfg.screen_height) << POS_FRAC_BITS;
    den4_r        <= tmag3_r;
    pay4_r.sing   <= sing3_r;
    pay4_r.neg_cx <= prod_r[42] ^ ty3_r[31];
    pay4_r.neg_sh <= nsh3_r;
    pay4_r.ty     <= ty3_r;
  end

  assign out_valid = v4_r;
  assign out_num   = num4_r;
  assign out_den   = den4_r;
  assign out_pay   = pay4_r;

endmodule

FILE: hw/rtl/scp_back.sv
// back stages: signed quotients, row and column spans, clamping and saturation
module scp_back #(
  parameter int NUM2_W            = scp_pkg::NUM2_MIN_W,
  parameter int SCREEN_COORD_BITS = scp_pkg::SCREEN_COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  scp_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  input  logic [2:0][NUM2_W-1:0]               in_quo,
  input  scp_pkg::div2_pay_t                   in_pay,
  output logic                                 out_valid,
  output logic                                 out_camera_singular,
  output logic                                 out_in_front,
  output logic signed [31:0]                   out_depth,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_center_column,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_vertical_shift,
  output logic [SCREEN_COORD_BITS-2:0]         out_sprite_height_rows,
  output logic [SCREEN_COORD_BITS-2:0]         out_sprite_width_cols,
  output logic [SCREEN_COORD_BITS-2:0]         out_row_start,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_row_end,
  output logic [SCREEN_COORD_BITS-2:0]         out_col_start,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_col_end
);

  localparam int S  = SCREEN_COORD_BITS;
  localparam int BW = NUM2_W + 3;
  localparam logic signed [BW-1:0] SMAX = BW'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [BW-1:0] SMIN = -SMAX - BW'(1);

  function automatic logic signed [S-1:0] sat_s(input logic signed [BW-1:0] x);
    logic signed [BW-1:0] c;
    c = (x > SMAX) ? SMAX : ((x < SMIN) ? SMIN : x);
    return c[S-1:0];
  endfunction

  function automatic logic [S-2:0] sat_u(input logic signed [BW-1:0] x);
    logic signed [BW-1:0] c;
    c = (x > SMAX) ? SMAX : ((x < 0) ? '0 : x);
    return c[S-2:0];
  endfunction

  // stage 1
  logic                v1_r, sing1_r;
  logic signed [NUM2_W:0] cx_r;
  logic signed [32:0]  sh_r;
  logic [NUM2_W-1:0]   hq_r;
  logic signed [31:0]  ty1_r;
  // stage 2
  logic                v2_r, sing2_r;
  logic signed [BW-1:0] cx2_r, sh2_r, ht_r, wd_r, rs_r, re_r, cs_r, ce_r;
  logic signed [31:0]  ty2_r;
  // stage 3, result registers
  logic                v3_r, sing3_r, front3_r;
  logic signed [31:0]  depth3_r;
  logic signed [S-1:0] cc3_r, vs3_r, re3_r, ce3_r;
  logic [S-2:0]        ht3_r, wd3_r, rs3_r, cs3_r;

  logic signed [NUM2_W:0] q0_ext;
  logic signed [32:0]     q1_ext;
  logic signed [BW-1:0]   cxe, she, hqs, hh, hs, ws;
  logic signed [BW-1:0]   rs_c, re_c, cs_c, ce_c;

  always_comb begin
    q0_ext = $signed({1'b0, in_quo[0]});
    q1_ext = $signed({1'b0, in_quo[1][31:0]});
    cxe    = BW'(cx_r);
    she    = BW'(sh_r);
    hqs    = $signed({3'b000, hq_r});
    hh     = $signed(BW'(cfg.screen_height[10:1]));
    hs     = $signed(BW'(cfg.screen_height));
    ws     = $signed(BW'(cfg.screen_width));
    rs_c   = (rs_r < 0) ? '0 : rs_r;
    re_c   = (re_r >= hs) ? hs - BW'(1) : re_r;
    cs_c   = (cs_r < 0) ? '0 : cs_r;
    ce_c   = (ce_r >= ws) ? ws : ce_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    cx_r    <= in_pay.neg_cx ? -q0_ext : q0_ext;
    sh_r    <= in_pay.neg_sh ? -q1_ext : q1_ext;
    hq_r    <= in_quo[2];
    sing1_r <= in_pay.sing;
    ty1_r   <= in_pay.ty;

    // height/2 is hq and width/2 is 2*hq exactly
    cx2_r   <= cxe;
    sh2_r   <= she;
    ht_r    <= hqs <<< 1;
    wd_r    <= hqs <<< 2;
    rs_r    <= hh - hqs + she;
    re_r    <= hh + hqs + she;
    cs_r    <= cxe - (hqs <<< 1);
    ce_r    <= cxe + (hqs <<< 1);
    sing2_r <= sing1_r;
    ty2_r   <= ty1_r;

    sing3_r <= sing2_r;
    if (sing2_r) begin
      front3_r <= 1'b0;
      depth3_r <= '0;
      cc3_r    <= '0;
      vs3_r    <= '0;
      ht3_r    <= '0;
      wd3_r    <= '0;
      rs3_r    <= '0;
      re3_r    <= '0;
      cs3_r    <= '0;
      ce3_r    <= '0;
    end else begin
      front3_r <= ~ty2_r[31];
      depth3_r <= ty2_r;
      cc3_r    <= sat_s(cx2_r);
      vs3_r    <= sat_s(sh2_r);
      ht3_r    <= sat_u(ht_r);
      wd3_r    <= sat_u(wd_r);
      rs3_r    <= sat_u(rs_c);
      re3_r    <= sat_s(re_c);
      cs3_r    <= sat_u(cs_c);
      ce3_r    <= sat_s(ce_c);
    end
  end

  assign out_valid              = v3_r;
  assign out_camera_singular    = sing3_r;
  assign out_in_front           = front3_r;
  assign out_depth              = depth3_r;
  assign out_center_column      = cc3_r;
  assign out_vertical_shift     = vs3_r;
  assign out_sprite_height_rows = ht3_r;
  assign out_sprite_width_cols  = wd3_r;
  assign out_row_start          = rs3_r;
  assign out_row_end            = re3_r;
  assign out_col_start          = cs3_r;
  assign out_col_end            = ce3_r;

endmodule

FILE: hw/rtl/sprite_camera_projection_unit.sv
// sprite camera projection: camera transform, screen projection and span clamping
// One sprite beat is taken every clock cycle (busy stays low) and its result appears
// on the out_ ports for one cycle, marked by out_valid, after passing the two
// bit-per-stage dividers: 64 stages for the camera transform and NUM2_W stages for
// the centre column, vertical shift and height divides, plus eleven arithmetic
// stages. The receiver cannot stall the pipeline, so every result must be taken
// on its strobe. Configuration writes are always ready and take effect at once;
// write them only while no sprite is in flight.
module sprite_camera_projection_unit #(
  parameter int POS_FRAC_BITS     = scp_pkg::POS_FRAC_BITS_DEF,
  parameter int SCREEN_COORD_BITS = scp_pkg::SCREEN_COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [31:0]                   in_sprite_x,
  input  logic signed [31:0]                   in_sprite_y,
  input  logic signed [31:0]                   in_vertical_move,
  output logic                                 out_valid,
  output logic                                 out_camera_singular,
  output logic                                 out_in_front,
  output logic signed [31:0]                   out_depth,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_center_column,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_vertical_shift,
  output logic [SCREEN_COORD_BITS-2:0]         out_sprite_height_rows,
  output logic [SCREEN_COORD_BITS-2:0]         out_sprite_width_cols,
  output logic [SCREEN_COORD_BITS-2:0]         out_row_start,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_row_end,
  output logic [SCREEN_COORD_BITS-2:0]         out_col_start,
  output logic signed [SCREEN_COORD_BITS-1:0]  out_col_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [scp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [scp_pkg::CFG_DAT_W-1:0]        cfg_data
);

  localparam int NUM2_W = (scp_pkg::NUM2_MIN_W > 11 + POS_FRAC_BITS) ?
                          scp_pkg::NUM2_MIN_W : 11 + POS_FRAC_BITS;

  scp_pkg::cfg_t cfg_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.player_pos_x  <= '0;
      cfg_r.player_pos_y  <= '0;
      cfg_r.dir_x         <= 16'sd16384;
      cfg_r.dir_y         <= '0;
      cfg_r.plane_x       <= '0;
      cfg_r.plane_y       <= 16'sd10813;
      cfg_r.screen_width  <= 11'd128;
      cfg_r.screen_height <= 11'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scp_pkg::CFG_PLAYER_POS_X: cfg_r.player_pos_x  <= cfg_data;
        scp_pkg::CFG_PLAYER_POS_Y: cfg_r.player_pos_y  <= cfg_data;
        scp_pkg::CFG_DIR_X:        cfg_r.dir_x         <= cfg_data[15:0];
        scp_pkg::CFG_DIR_Y:        cfg_r.dir_y         <= cfg_data[15:0];
        scp_pkg::CFG_PLANE_X:      cfg_r.plane_x       <= cfg_data[15:0];
        scp_pkg::CFG_PLANE_Y:      cfg_r.plane_y       <= cfg_data[15:0];
        scp_pkg::CFG_SCREEN_W:     cfg_r.screen_width  <= cfg_data[10:0];
        scp_pkg::CFG_SCREEN_H:     cfg_r.screen_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic                            f_valid;
  logic [1:0][scp_pkg::NUM1_W-1:0] f_num;
  logic [scp_pkg::DEN_W-1:0]       f_den;
  scp_pkg::div1_pay_t              f_pay;

  logic                            d1_valid;
  logic [1:0][scp_pkg::NUM1_W-1:0] d1_quo;
  scp_pkg::div1_pay_t              d1_pay;

  logic                            m_valid;
  logic [2:0][NUM2_W-1:0]          m_num;
  logic [scp_pkg::DEN_W-1:0]       m_den;
  scp_pkg::div2_pay_t              m_pay;

  logic                            d2_valid;
  logic [2:0][NUM2_W-1:0]          d2_quo;
  scp_pkg::div2_pay_t              d2_pay;

  scp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (start && !busy),
    .sprite_x      (in_sprite_x),
    .sprite_y      (in_sprite_y),
    .vertical_move (in_vertical_move),
    .out_valid     (f_valid),
    .out_num       (f_num),
    .out_den       (f_den),
    .out_pay       (f_pay)
  );

  scp_div_pipe #(
    .LANES (2),
    .NW    (scp_pkg::NUM1_W),
    .DW    (scp_pkg::DEN_W),
    .PW    ($bits(scp_pkg::div1_pay_t))
  ) u_div_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_pay    (f_pay),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_pay   (d1_pay)
  );

  scp_mid #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .NUM2_W        (NUM2_W)
  ) u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (d1_valid),
    .in_quo    (d1_quo),
    .in_pay    (d1_pay),
    .out_valid (m_valid),
    .out_num   (m_num),
    .out_den   (m_den),
    .out_pay   (m_pay)
  );

  scp_div_pipe #(
    .LANES (3),
    .NW    (NUM2_W),
    .DW    (scp_pkg::DEN_W),
    .PW    ($bits(scp_pkg::div2_pay_t))
  ) u_div_scr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_num    (m_num),
    .in_den    (m_den),
    .in_pay    (m_pay),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_pay   (d2_pay)
  );

  scp_back #(
    .NUM2_W            (NUM2_W),
    .SCREEN_COORD_BITS (SCREEN_COORD_BITS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .in_valid               (d2_valid),
    .in_quo                 (d2_quo),
    .in_pay                 (d2_pay),
    .out_valid              (out_valid),
    .out_camera_singular    (out_camera_singular),
    .out_in_front           (out_in_front),
    .out_depth              (out_depth),
    .out_center_column      (out_center_column),
    .out_vertical_shift     (out_vertical_shift),
    .out_sprite_height_rows (out_sprite_height_rows),
    .out_sprite_width_cols  (out_sprite_width_cols),
    .out_row_start          (out_row_start),
    .out_row_end            (out_row_end),
    .out_col_start          (out_col_start),
    .out_col_end            (out_col_end)
  );

`ifndef SYNTHESIS
  // a singular beat carries no geometry
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_camera_singular |-> out_depth == '0 && !out_in_front &&
      out_sprite_height_rows == '0 && out_col_end == '0)
    else $error("singular result carries geometry");

  // in front means a positive depth
  a_front_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_front |-> out_depth > 0)
    else $error("in_front with non-positive depth");

  // spans never pass the screen edge
  a_span_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_camera_singular |->
      $signed(out_row_end) < $signed({1'b0, cfg_r.screen_height}) &&
      $signed(out_col_end) <= $signed({1'b0, cfg_r.screen_width}))
    else $error("span exceeds screen");
`endif

endmodule
